// ----- hdl/gsff_pkg.sv -----
// ----------------------------------------------------------------------------
// gsff_pkg
// Shared types, codes and widths of the gravity stress face flux pipeline.
// ----------------------------------------------------------------------------
package gsff_pkg;

	// magnitude width of a Q16.16 gradient
	localparam int GW = 47;
	// magnitude width of a squared or cross gradient term
	localparam int MW = 94;
	// width of the mean density times potential sum product
	localparam int JW = 65;
	// width of a signed flux accumulator before rounding
	localparam int TW = 127;
	// width of one result component
	localparam int FW = 48;

	// face normal axis codes, also used as axis numbers
	localparam logic [1:0] KIND_AXIS1 = 2'd0;
	localparam logic [1:0] KIND_AXIS2 = 2'd1;
	localparam logic [1:0] KIND_AXIS3 = 2'd2;
	localparam logic [1:0] KIND_NONE  = 2'd3;

	// configuration register indexes
	localparam logic [2:0] REG_INV_FOUR_PI_G = 3'd0;
	localparam logic [2:0] REG_MEAN_RHO      = 3'd1;
	localparam logic [2:0] REG_INV_DX1       = 3'd2;
	localparam logic [2:0] REG_INV_DX2       = 3'd3;
	localparam logic [2:0] REG_INV_DX3       = 3'd4;
	localparam logic [2:0] REG_DIMS          = 3'd5;

	localparam logic [FW-1:0] FLUX_MAX = {1'b0, {(FW-1){1'b1}}};
	localparam logic [FW-1:0] FLUX_MIN = {1'b1, {(FW-1){1'b0}}};

	typedef struct packed {
		logic [30:0]        inv_four_pi_g;
		logic signed [31:0] mean_rho;
		logic [30:0]        inv_dx1;
		logic [30:0]        inv_dx2;
		logic [30:0]        inv_dx3;
		logic [1:0]         dims;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] pot_left;
		logic signed [31:0] pot_right;
		logic signed [31:0] ta_left_minus;
		logic signed [31:0] ta_left_plus;
		logic signed [31:0] ta_right_minus;
		logic signed [31:0] ta_right_plus;
		logic signed [31:0] tb_left_minus;
		logic signed [31:0] tb_left_plus;
		logic signed [31:0] tb_right_minus;
		logic signed [31:0] tb_right_plus;
	} face_t;

	// gradients as magnitude and sign: normal, first and second transverse axis
	typedef struct packed {
		logic [GW-1:0]        gn;
		logic [GW-1:0]        ga;
		logic [GW-1:0]        gb;
		logic                 neg_n;
		logic                 neg_a;
		logic                 neg_b;
		logic signed [JW-1:0] jt;
		logic [1:0]           kind;
	} grad_t;

	// squares and cross products of the gradients
	typedef struct packed {
		logic [MW-1:0]        sqn;
		logic [MW-1:0]        sqa;
		logic [MW-1:0]        sqb;
		logic [MW-1:0]        cxa;
		logic [MW-1:0]        cxb;
		logic                 neg_a;
		logic                 neg_b;
		logic signed [JW-1:0] jt;
		logic [1:0]           kind;
	} sq_t;

	// flux accumulators with 48 fraction bits (normal one also holds the half)
	typedef struct packed {
		logic signed [TW-1:0] t_n;
		logic signed [TW-1:0] t_a;
		logic signed [TW-1:0] t_b;
		logic [1:0]           kind;
	} acc_t;

	typedef struct packed {
		logic [FW-1:0] flux1;
		logic [FW-1:0] flux2;
		logic [FW-1:0] flux3;
		logic          sat;
	} res_t;

endpackage

// ----- hdl/gsff_grad.sv -----
// ----------------------------------------------------------------------------
// gsff_grad
// Stages 1-3: stencil differences, scaling by reciprocal spacing, rounding.
// ----------------------------------------------------------------------------
module gsff_grad (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_valid,
	input  gsff_pkg::face_t   face,
	input  gsff_pkg::cfg_t    cfg,
	output logic              out_valid,
	output gsff_pkg::grad_t   grad
);

	logic [1:0]  nd;
	logic [1:0]  ta_ax;
	logic [1:0]  tb_ax;
	logic        face_off;
	logic        ta_on;
	logic        tb_on;
	logic [32:0] dn;
	logic [32:0] psum;
	logic [33:0] da;
	logic [33:0] db;
	logic [32:0] dn_mag;
	logic [33:0] da_mag;
	logic [33:0] db_mag;
	logic [30:0] inv_n;
	logic [30:0] inv_a;
	logic [30:0] inv_b;

	logic        v_s1;
	logic [32:0] mag_n_s1;
	logic [33:0] mag_a_s1;
	logic [33:0] mag_b_s1;
	logic        neg_n_s1;
	logic        neg_a_s1;
	logic        neg_b_s1;
	logic [32:0] psum_s1;
	logic [30:0] inv_n_s1;
	logic [30:0] inv_a_s1;
	logic [30:0] inv_b_s1;
	logic [1:0]  kind_s1;

	logic                 v_s2;
	logic [63:0]          prod_n_s2;
	logic [64:0]          prod_a_s2;
	logic [64:0]          prod_b_s2;
	logic signed [64:0]   jt_s2;
	logic                 neg_n_s2;
	logic                 neg_a_s2;
	logic                 neg_b_s2;
	logic [1:0]           kind_s2;

	logic [63:0] rnd_n;
	logic [64:0] rnd_a;
	logic [64:0] rnd_b;

	logic                v_s3;
	gsff_pkg::grad_t     grad_s3;

	always_comb begin
		nd = (cfg.dims == 2'd0) ? 2'd1 : cfg.dims;
		face_off = (face.kind == gsff_pkg::KIND_NONE) || (face.kind >= nd);
		ta_ax = (face.kind == gsff_pkg::KIND_AXIS1) ? gsff_pkg::KIND_AXIS2 : gsff_pkg::KIND_AXIS1;
		tb_ax = (face.kind == gsff_pkg::KIND_AXIS3) ? gsff_pkg::KIND_AXIS2 : gsff_pkg::KIND_AXIS3;
		ta_on = !face_off && (ta_ax < nd);
		tb_on = !face_off && (tb_ax < nd);

		dn = {face.pot_left[31], face.pot_left} - {face.pot_right[31], face.pot_right};
		psum = {face.pot_left[31], face.pot_left} + {face.pot_right[31], face.pot_right};
		da = ({{2{face.ta_left_minus[31]}}, face.ta_left_minus}
			- {{2{face.ta_left_plus[31]}}, face.ta_left_plus})
			+ ({{2{face.ta_right_minus[31]}}, face.ta_right_minus}
			- {{2{face.ta_right_plus[31]}}, face.ta_right_plus});
		db = ({{2{face.tb_left_minus[31]}}, face.tb_left_minus}
			- {{2{face.tb_left_plus[31]}}, face.tb_left_plus})
			+ ({{2{face.tb_right_minus[31]}}, face.tb_right_minus}
			- {{2{face.tb_right_plus[31]}}, face.tb_right_plus});

		// the most negative difference still fits as an unsigned magnitude
		dn_mag = dn[32] ? (~dn + 33'd1) : dn;
		da_mag = da[33] ? (~da + 34'd1) : da;
		db_mag = db[33] ? (~db + 34'd1) : db;

		case (face.kind)
			gsff_pkg::KIND_AXIS1: inv_n = cfg.inv_dx1;
			gsff_pkg::KIND_AXIS2: inv_n = cfg.inv_dx2;
			default:              inv_n = cfg.inv_dx3;
		endcase
		inv_a = (face.kind == gsff_pkg::KIND_AXIS1) ? cfg.inv_dx2 : cfg.inv_dx1;
		inv_b = (face.kind == gsff_pkg::KIND_AXIS3) ? cfg.inv_dx2 : cfg.inv_dx3;
	end

	// stage 1: differences; zero the terms of an inactive axis or face
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_n_s1 <= face_off ? 33'd0 : dn_mag;
			mag_a_s1 <= ta_on ? da_mag : 34'd0;
			mag_b_s1 <= tb_on ? db_mag : 34'd0;
			neg_n_s1 <= dn[32];
			neg_a_s1 <= da[33];
			neg_b_s1 <= db[33];
			psum_s1  <= face_off ? 33'd0 : psum;
			inv_n_s1 <= inv_n;
			inv_a_s1 <= inv_a;
			inv_b_s1 <= inv_b;
			kind_s1  <= face.kind;
		end
	end

	// stage 2: scale by reciprocal spacing, form the density term
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_n_s2 <= {31'd0, mag_n_s1} * {33'd0, inv_n_s1};
			prod_a_s2 <= {31'd0, mag_a_s1} * {34'd0, inv_a_s1};
			prod_b_s2 <= {31'd0, mag_b_s1} * {34'd0, inv_b_s1};
			jt_s2 <= $signed({{33{cfg.mean_rho[31]}}, cfg.mean_rho})
				* $signed({{32{psum_s1[32]}}, psum_s1});
			neg_n_s2 <= neg_n_s1;
			neg_a_s2 <= neg_a_s1;
			neg_b_s2 <= neg_b_s1;
			kind_s2  <= kind_s1;
		end
	end

	// stage 3: round half away from zero (sign kept apart)
	always_comb begin
		rnd_n = prod_n_s2 + 64'h8000;
		rnd_a = prod_a_s2 + 65'h2_0000;
		rnd_b = prod_b_s2 + 65'h2_0000;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			grad_s3.gn    <= rnd_n[62:16];
			grad_s3.ga    <= rnd_a[64:18];
			grad_s3.gb    <= rnd_b[64:18];
			grad_s3.neg_n <= neg_n_s2;
			grad_s3.neg_a <= neg_a_s2;
			grad_s3.neg_b <= neg_b_s2;
			grad_s3.jt    <= jt_s2;
			grad_s3.kind  <= kind_s2;
		end
	end

	assign out_valid = v_s3;
	assign grad      = grad_s3;

endmodule

// ----- hdl/gsff_square.sv -----
// ----------------------------------------------------------------------------
// gsff_square
// Stages 4-5: gradient squares and cross products from 24-bit partial products.
// ----------------------------------------------------------------------------
module gsff_square (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_valid,
	input  gsff_pkg::grad_t   grad,
	output logic              out_valid,
	output gsff_pkg::sq_t     sq
);

	typedef struct packed {
		logic [45:0] hh;
		logic [46:0] hl;
		logic [46:0] lh;
		logic [47:0] ll;
	} pp_t;

	function automatic pp_t pp_mul(input logic [46:0] x, input logic [46:0] y);
		pp_t p;
		p.hh = {23'd0, x[46:24]} * {23'd0, y[46:24]};
		p.hl = {24'd0, x[46:24]} * {23'd0, y[23:0]};
		p.lh = {23'd0, x[23:0]} * {24'd0, y[46:24]};
		p.ll = {24'd0, x[23:0]} * {24'd0, y[23:0]};
		return p;
	endfunction

	function automatic logic [93:0] pp_sum(input pp_t p);
		return {p.hh, 48'd0} + {23'd0, p.hl, 24'd0} + {23'd0, p.lh, 24'd0} + {46'd0, p.ll};
	endfunction

	logic                v_s4;
	pp_t                 pp_nn_s4;
	pp_t                 pp_aa_s4;
	pp_t                 pp_bb_s4;
	pp_t                 pp_na_s4;
	pp_t                 pp_nb_s4;
	logic                neg_a_s4;
	logic                neg_b_s4;
	logic signed [64:0]  jt_s4;
	logic [1:0]          kind_s4;

	logic                v_s5;
	gsff_pkg::sq_t       sq_s5;

	// stage 4: partial products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pp_nn_s4 <= pp_mul(grad.gn, grad.gn);
			pp_aa_s4 <= pp_mul(grad.ga, grad.ga);
			pp_bb_s4 <= pp_mul(grad.gb, grad.gb);
			pp_na_s4 <= pp_mul(grad.gn, grad.ga);
			pp_nb_s4 <= pp_mul(grad.gn, grad.gb);
			neg_a_s4 <= grad.neg_n ^ grad.neg_a;
			neg_b_s4 <= grad.neg_n ^ grad.neg_b;
			jt_s4    <= grad.jt;
			kind_s4  <= grad.kind;
		end
	end

	// stage 5: sum the partials
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s5.sqn   <= pp_sum(pp_nn_s4);
			sq_s5.sqa   <= pp_sum(pp_aa_s4);
			sq_s5.sqb   <= pp_sum(pp_bb_s4);
			sq_s5.cxa   <= pp_sum(pp_na_s4);
			sq_s5.cxb   <= pp_sum(pp_nb_s4);
			sq_s5.neg_a <= neg_a_s4;
			sq_s5.neg_b <= neg_b_s4;
			sq_s5.jt    <= jt_s4;
			sq_s5.kind  <= kind_s4;
		end
	end

	assign out_valid = v_s5;
	assign sq        = sq_s5;

endmodule

// ----- hdl/gsff_scale.sv -----
// ----------------------------------------------------------------------------
// gsff_scale
// Stages 6-10: normal stress sum, scaling by 1/(4 pi G), sign and density term.
// ----------------------------------------------------------------------------
module gsff_scale (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_valid,
	input  gsff_pkg::sq_t     sq,
	input  gsff_pkg::cfg_t    cfg,
	output logic              out_valid,
	output gsff_pkg::acc_t    acc
);

	// lane 0 normal component, lane 1 first transverse, lane 2 second transverse
	logic                v_s6;
	logic [95:0]         diff_s6;
	logic [93:0]         cxa_s6;
	logic [93:0]         cxb_s6;
	logic                neg_a_s6;
	logic                neg_b_s6;
	logic signed [64:0]  jt_s6;
	logic [1:0]          kind_s6;

	logic [95:0]         diff_mag;

	logic                v_s7;
	logic [93:0]         mag_s7 [3];
	logic [2:0]          neg_s7;
	logic signed [64:0]  jt_s7;
	logic [1:0]          kind_s7;

	logic                v_s8;
	logic [62:0]         p0_s8 [3];
	logic [62:0]         p1_s8 [3];
	logic [60:0]         p2_s8 [3];
	logic [2:0]          neg_s8;
	logic signed [64:0]  jt_s8;
	logic [1:0]          kind_s8;

	logic                v_s9;
	logic [124:0]        m_s9 [3];
	logic [2:0]          neg_s9;
	logic signed [64:0]  jt_s9;
	logic [1:0]          kind_s9;

	logic [126:0]        mx [3];
	logic [126:0]        tv [3];
	logic [126:0]        js;

	logic                v_s10;
	gsff_pkg::acc_t      acc_s10;

	// stage 6: normal square minus transverse squares
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s6 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			diff_s6  <= {2'b00, sq.sqn} - {2'b00, sq.sqa} - {2'b00, sq.sqb};
			cxa_s6   <= sq.cxa;
			cxb_s6   <= sq.cxb;
			neg_a_s6 <= sq.neg_a;
			neg_b_s6 <= sq.neg_b;
			jt_s6    <= sq.jt;
			kind_s6  <= sq.kind;
		end
	end

	// stage 7: magnitude and sign on every lane
	assign diff_mag = diff_s6[95] ? (~diff_s6 + 96'd1) : diff_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s7[0] <= diff_mag[93:0];
			mag_s7[1] <= cxa_s6;
			mag_s7[2] <= cxb_s6;
			neg_s7    <= {neg_b_s6, neg_a_s6, diff_s6[95]};
			jt_s7     <= jt_s6;
			kind_s7   <= kind_s6;
		end
	end

	// stage 8: 32-bit slices times the reciprocal of 4 pi G
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				p0_s8[i] <= {31'd0, mag_s7[i][31:0]} * {32'd0, cfg.inv_four_pi_g};
				p1_s8[i] <= {31'd0, mag_s7[i][63:32]} * {32'd0, cfg.inv_four_pi_g};
				p2_s8[i] <= {31'd0, mag_s7[i][93:64]} * {30'd0, cfg.inv_four_pi_g};
			end
			neg_s8  <= neg_s7;
			jt_s8   <= jt_s7;
			kind_s8 <= kind_s7;
		end
	end

	// stage 9: sum the slices
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (adv) begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				m_s9[i] <= {62'd0, p0_s8[i]} + {30'd0, p1_s8[i], 32'd0} + {p2_s8[i], 64'd0};
			end
			neg_s9  <= neg_s8;
			jt_s9   <= jt_s8;
			kind_s9 <= kind_s8;
		end
	end

	// stage 10: restore sign, add the density term to the normal lane
	always_comb begin
		js = {{46{jt_s9[64]}}, jt_s9, 16'd0};
		for (int i = 0; i < 3; i++) begin
			mx[i] = {2'b00, m_s9[i]};
			tv[i] = neg_s9[i] ? (~mx[i] + 127'd1) : mx[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (adv) begin
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			acc_s10.t_n  <= tv[0] + js;
			acc_s10.t_a  <= tv[1];
			acc_s10.t_b  <= tv[2];
			acc_s10.kind <= kind_s9;
		end
	end

	assign out_valid = v_s10;
	assign acc       = acc_s10;

endmodule

// ----- hdl/gsff_out.sv -----
// ----------------------------------------------------------------------------
// gsff_out
// Final rounding and saturation, axis mapping, output register with skid.
// ----------------------------------------------------------------------------
module gsff_out (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  gsff_pkg::acc_t    acc,
	output logic              ready,
	output logic              m_valid,
	input  logic              m_ready,
	output gsff_pkg::res_t    res
);

	// returns {clipped, value} of a shifted accumulator
	function automatic logic [48:0] clip48(input logic [94:0] r);
		logic [48:0] c;
		if (r[94:47] == {48{r[94]}}) begin
			c = {1'b0, r[47:0]};
		end else if (r[94]) begin
			c = {1'b1, gsff_pkg::FLUX_MIN};
		end else begin
			c = {1'b1, gsff_pkg::FLUX_MAX};
		end
		return c;
	endfunction

	logic [126:0]     u_n;
	logic [126:0]     u_a;
	logic [126:0]     u_b;
	logic [48:0]      c_n;
	logic [48:0]      c_a;
	logic [48:0]      c_b;
	gsff_pkg::res_t   res_d;

	logic             out_v_q;
	gsff_pkg::res_t   out_q;
	logic             skid_v_q;
	gsff_pkg::res_t   skid_q;

	always_comb begin
		// round half up: normal lane drops 33 bits, transverse lanes 32
		u_n = acc.t_n + 127'h1_0000_0000;
		u_a = acc.t_a + 127'h8000_0000;
		u_b = acc.t_b + 127'h8000_0000;
		c_n = clip48({u_n[126], u_n[126:33]});
		c_a = clip48(u_a[126:32]);
		c_b = clip48(u_b[126:32]);

		case (acc.kind)
			gsff_pkg::KIND_AXIS1: begin
				res_d.flux1 = c_n[47:0];
				res_d.flux2 = c_a[47:0];
				res_d.flux3 = c_b[47:0];
			end
			gsff_pkg::KIND_AXIS2: begin
				res_d.flux1 = c_a[47:0];
				res_d.flux2 = c_n[47:0];
				res_d.flux3 = c_b[47:0];
			end
			default: begin
				res_d.flux1 = c_a[47:0];
				res_d.flux2 = c_b[47:0];
				res_d.flux3 = c_n[47:0];
			end
		endcase
		res_d.sat = c_n[48] | c_a[48] | c_b[48];
	end

	// the pipeline advances only while the skid is empty
	assign ready = !skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (m_ready || !out_v_q) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= in_valid;
			end
		end else if (in_valid && !skid_v_q) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (m_ready || !out_v_q) begin
			out_q <= skid_v_q ? skid_q : res_d;
		end else if (!skid_v_q) begin
			skid_q <= res_d;
		end
	end

	assign m_valid = out_v_q;
	assign res     = out_q;

endmodule

// ----- hdl/gravity_stress_face_flux_core.sv -----
// ----------------------------------------------------------------------------
// gravity_stress_face_flux_core
// Gravitational stress-tensor momentum flux of one cell face per item.
// ----------------------------------------------------------------------------
// One face enters per clock while the pipeline advances, and its result
// passes through ten pipeline stages (differences, spacing multiply,
// rounding, gradient partial products, their sums, the normal stress sum,
// magnitude, slice multiply by 1/(4 pi G), slice sum, sign and density term),
// the first loaded at the accepting edge, and then the output register. Every
// multiplier is used once per item, so throughput is one face per clock while
// the master side takes results. The output register has a skid entry behind
// it; s_axis_tready drops only when both hold a result. A face whose normal
// axis lies beyond the configured dimensionality gives zero flux.
// Configuration writes are taken at any time but must only be made while no
// item is in flight.
// ----------------------------------------------------------------------------
module gravity_stress_face_flux_core (
	input  logic          clk,
	input  logic          arst_n,

	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [2:0]    cfg_index,
	input  logic [31:0]   cfg_data,

	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	// pot_left, pot_right, ta_left_minus, ta_left_plus, ta_right_minus,
	// ta_right_plus, tb_left_minus, tb_left_plus, tb_right_minus, tb_right_plus
	input  logic [319:0]  s_axis_tdata,
	// kind
	input  logic [1:0]    s_axis_tuser,

	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	// mom_flux_1, mom_flux_2, mom_flux_3
	output logic [143:0]  m_axis_tdata,
	// saturated
	output logic [0:0]    m_axis_tuser
);

	gsff_pkg::cfg_t    cfg_q;
	gsff_pkg::face_t   face;
	gsff_pkg::grad_t   grad;
	gsff_pkg::sq_t     sq;
	gsff_pkg::acc_t    acc;
	gsff_pkg::res_t    res;

	logic adv;
	logic grad_valid;
	logic sq_valid;
	logic acc_valid;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inv_four_pi_g <= 31'd65536;
			cfg_q.mean_rho      <= 32'sd0;
			cfg_q.inv_dx1       <= 31'd65536;
			cfg_q.inv_dx2       <= 31'd65536;
			cfg_q.inv_dx3       <= 31'd65536;
			cfg_q.dims          <= 2'd3;
		end else if (cfg_valid) begin
			case (cfg_index)
				gsff_pkg::REG_INV_FOUR_PI_G: cfg_q.inv_four_pi_g <= cfg_data[30:0];
				gsff_pkg::REG_MEAN_RHO:      cfg_q.mean_rho      <= cfg_data;
				gsff_pkg::REG_INV_DX1:       cfg_q.inv_dx1       <= cfg_data[30:0];
				gsff_pkg::REG_INV_DX2:       cfg_q.inv_dx2       <= cfg_data[30:0];
				gsff_pkg::REG_INV_DX3:       cfg_q.inv_dx3       <= cfg_data[30:0];
				gsff_pkg::REG_DIMS:          cfg_q.dims          <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		face.kind           = s_axis_tuser;
		face.pot_left       = s_axis_tdata[31:0];
		face.pot_right      = s_axis_tdata[63:32];
		face.ta_left_minus  = s_axis_tdata[95:64];
		face.ta_left_plus   = s_axis_tdata[127:96];
		face.ta_right_minus = s_axis_tdata[159:128];
		face.ta_right_plus  = s_axis_tdata[191:160];
		face.tb_left_minus  = s_axis_tdata[223:192];
		face.tb_left_plus   = s_axis_tdata[255:224];
		face.tb_right_minus = s_axis_tdata[287:256];
		face.tb_right_plus  = s_axis_tdata[319:288];
	end

	assign s_axis_tready = adv;

	gsff_grad u_grad (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (s_axis_tvalid),
		.face      (face),
		.cfg       (cfg_q),
		.out_valid (grad_valid),
		.grad      (grad)
	);

	gsff_square u_square (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (grad_valid),
		.grad      (grad),
		.out_valid (sq_valid),
		.sq        (sq)
	);

	gsff_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (sq_valid),
		.sq        (sq),
		.cfg       (cfg_q),
		.out_valid (acc_valid),
		.acc       (acc)
	);

	gsff_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (acc_valid),
		.acc      (acc),
		.ready    (adv),
		.m_valid  (m_axis_tvalid),
		.m_ready  (m_axis_tready),
		.res      (res)
	);

	assign m_axis_tdata = {res.flux3, res.flux2, res.flux1};
	assign m_axis_tuser = res.sat;

	// a held pipeline means both output entries are full
	a_stall_has_output: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |-> m_axis_tvalid)
		else $error("pipeline stalled with no result on the output");

	// an item arriving at a blocked output must park in the skid entry
	a_park_in_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready && acc_valid && adv) |=> !adv)
		else $error("item reached a blocked output without filling the skid");

	// a clipped result has at least one component at a limit
	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0]) |->
		(res.flux1 == gsff_pkg::FLUX_MAX || res.flux1 == gsff_pkg::FLUX_MIN ||
		res.flux2 == gsff_pkg::FLUX_MAX || res.flux2 == gsff_pkg::FLUX_MIN ||
		res.flux3 == gsff_pkg::FLUX_MAX || res.flux3 == gsff_pkg::FLUX_MIN))
		else $error("saturation flagged but no component is clipped");

endmodule

// ----- dv/gsff_flux_board_pkg.sv -----
// ----------------------------------------------------------------------------
// gsff_flux_board_pkg
// Scoreboard of the face flux testbench: keeps its own copy of the registers,
// predicts the momentum flux of every accepted face and checks each result
// against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
package gsff_flux_board_pkg;

	// wide enough for every exact flux sum with 48 fraction bits
	typedef logic signed [159:0] wide_t;

	class face_flux_board;

		logic [30:0]        inv_four_pi_g;
		logic signed [31:0] mean_rho;
		logic [30:0]        inv_dx[3];
		logic [1:0]         dims;
		gsff_pkg::res_t     flux_due[$];
		int                 mismatches;
		int                 results_seen;

		function new();
			inv_four_pi_g = 31'd65536;
			mean_rho      = '0;
			inv_dx[0]     = 31'd65536;
			inv_dx[1]     = 31'd65536;
			inv_dx[2]     = 31'd65536;
			dims          = 2'd3;
			mismatches    = 0;
			results_seen  = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] data);
			case (idx)
			gsff_pkg::REG_INV_FOUR_PI_G: inv_four_pi_g = data[30:0];
			gsff_pkg::REG_MEAN_RHO:      mean_rho = data;
			gsff_pkg::REG_INV_DX1:       inv_dx[0] = data[30:0];
			gsff_pkg::REG_INV_DX2:       inv_dx[1] = data[30:0];
			gsff_pkg::REG_INV_DX3:       inv_dx[2] = data[30:0];
			gsff_pkg::REG_DIMS:          dims = data[1:0];
			default: ;
			endcase
		endfunction

		// |diff| * inv, rounded half away from zero at bit sh, sign put back after
		function longint grad_of(longint diff, longint unsigned inv, int sh);
			longint unsigned p;
			p = (diff < 0) ? -diff : diff;
			p = p * inv;
			p = (p + (64'd1 << (sh - 1))) >> sh;
			return (diff < 0) ? -longint'(p) : longint'(p);
		endfunction

		// round half up at bit sh, then clip to 48 bits; the top bit flags a clip
		function logic [48:0] round_sat(wide_t t, int sh);
			wide_t v;
			v = (t + (wide_t'(1) <<< (sh - 1))) >>> sh;
			if (v > wide_t'(gsff_pkg::FLUX_MAX))
				return {1'b1, gsff_pkg::FLUX_MAX};
			if (v < -wide_t'(gsff_pkg::FLUX_MAX) - 1)
				return {1'b1, gsff_pkg::FLUX_MIN};
			return {1'b0, v[47:0]};
		endfunction

		function gsff_pkg::res_t flux_of_face(gsff_pkg::face_t f);
			longint         pl, pr, d;
			longint         g[3];
			longint         sten[2][4];
			int             tax[2];
			int             nd, n, a;
			wide_t          k, sq, jt;
			logic [48:0]    rs[3];
			gsff_pkg::res_t r;
			r = '0;
			nd = (dims == 2'd0) ? 1 : int'(dims);
			if (f.kind == gsff_pkg::KIND_NONE || int'(f.kind) >= nd)
				return r;
			pl = longint'(f.pot_left);
			pr = longint'(f.pot_right);
			sten[0][0] = longint'(f.ta_left_minus);
			sten[0][1] = longint'(f.ta_left_plus);
			sten[0][2] = longint'(f.ta_right_minus);
			sten[0][3] = longint'(f.ta_right_plus);
			sten[1][0] = longint'(f.tb_left_minus);
			sten[1][1] = longint'(f.tb_left_plus);
			sten[1][2] = longint'(f.tb_right_minus);
			sten[1][3] = longint'(f.tb_right_plus);
			// transverse axes in ascending order
			n = 0;
			for (a = 0; a < 3; a++) begin
				if (a != int'(f.kind)) begin
					tax[n] = a;
					n++;
				end
			end
			for (a = 0; a < 3; a++)
				g[a] = 0;
			g[f.kind] = grad_of(pl - pr, inv_dx[f.kind], 16);
			// the quarter weight sits in the wider shift
			for (a = 0; a < 2; a++) begin
				if (tax[a] < nd) begin
					d = (sten[a][0] - sten[a][1]) + (sten[a][2] - sten[a][3]);
					g[tax[a]] = grad_of(d, inv_dx[tax[a]], 18);
				end
			end
			k = wide_t'(inv_four_pi_g);
			for (a = 0; a < 3; a++) begin
				if (a == int'(f.kind)) begin
					sq = wide_t'(g[a]) * wide_t'(g[a])
						- wide_t'(g[tax[0]]) * wide_t'(g[tax[0]])
						- wide_t'(g[tax[1]]) * wide_t'(g[tax[1]]);
					jt = wide_t'(mean_rho) * (wide_t'(pl) + wide_t'(pr));
					rs[a] = round_sat(sq * k + (jt <<< 16), 33);
				end else begin
					rs[a] = round_sat(wide_t'(g[f.kind]) * wide_t'(g[a]) * k, 32);
				end
			end
			r.flux1 = rs[0][47:0];
			r.flux2 = rs[1][47:0];
			r.flux3 = rs[2][47:0];
			r.sat   = rs[0][48] | rs[1][48] | rs[2][48];
			return r;
		endfunction

		function void note_face(gsff_pkg::face_t f);
			flux_due.push_back(flux_of_face(f));
		endfunction

		task report_mismatch(string what, logic [47:0] got, logic [47:0] want);
			mismatches++;
			if (mismatches <= 40)
				$display("result %0d %s: got %h, want %h", results_seen, what, got, want);
		endtask

		task check_result(gsff_pkg::res_t got);
			gsff_pkg::res_t want;
			results_seen++;
			if (flux_due.size() == 0) begin
				report_mismatch("arrived with nothing pending", got.flux1, '0);
				return;
			end
			want = flux_due.pop_front();
			if (got.flux1 !== want.flux1)
				report_mismatch("mom_flux_1", got.flux1, want.flux1);
			if (got.flux2 !== want.flux2)
				report_mismatch("mom_flux_2", got.flux2, want.flux2);
			if (got.flux3 !== want.flux3)
				report_mismatch("mom_flux_3", got.flux3, want.flux3);
			if (got.sat !== want.sat)
				report_mismatch("saturated", 48'(got.sat), 48'(want.sat));
		endtask

	endclass

endpackage

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Stream test of the face flux core: directed faces at the field extremes and
// rounding halves, then random stencils over phases with different register
// settings and idle patterns, one long output hold-off to fill the pipeline,
// and every result compared field by field with the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          PIPE_CYCLES  = 10;
	localparam int          QUIET_LIMIT  = 4000;
	localparam int          PHASES       = 10;
	localparam logic [2:0]  REG_SPARE_LO = 3'd6;
	localparam logic [2:0]  REG_SPARE_HI = 3'd7;
	localparam logic [31:0] POT_MAX      = 32'h7FFF_FFFF;
	localparam logic [31:0] POT_MIN      = 32'h8000_0000;
	localparam logic [31:0] ONE_Q        = 32'h0001_0000;

	logic         clk;
	logic         arst_n;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [2:0]   cfg_index;
	logic [31:0]  cfg_data;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [319:0] s_axis_tdata;
	logic [1:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [143:0] m_axis_tdata;
	logic [0:0]   m_axis_tuser;

	gsff_flux_board_pkg::face_flux_board sb;
	gsff_pkg::face_t face_drv;
	int              send_idle_pct  = 0;
	int              recv_stall_pct = 0;
	int              rx_hold        = 0;
	int              quiet          = 0;

	gravity_stress_face_flux_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// result side: a long hold-off when asked, else random stalls
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			m_axis_tready = 1'b0;
			rx_hold = rx_hold - 1;
		end else begin
			m_axis_tready = ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin : watch_bus
		gsff_pkg::res_t got;
		got.flux1 = m_axis_tdata[47:0];
		got.flux2 = m_axis_tdata[95:48];
		got.flux3 = m_axis_tdata[143:96];
		got.sat   = m_axis_tuser[0];
		if (s_axis_tvalid && s_axis_tready)
			sb.note_face(face_drv);
		if (m_axis_tvalid && m_axis_tready)
			sb.check_result(got);
		if (cfg_valid && cfg_ready)
			sb.write_reg(cfg_index, cfg_data);
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			quiet = 0;
		else
			quiet = quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
			$display("status: fail");
			$finish;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// write all six registers, then optionally poke the unused indexes
	task automatic load_registers(input logic [31:0] k, rho, dx1, dx2, dx3, nd,
			input bit spare);
		write_reg(gsff_pkg::REG_INV_FOUR_PI_G, k);
		write_reg(gsff_pkg::REG_MEAN_RHO, rho);
		write_reg(gsff_pkg::REG_INV_DX1, dx1);
		write_reg(gsff_pkg::REG_INV_DX2, dx2);
		write_reg(gsff_pkg::REG_INV_DX3, dx3);
		write_reg(gsff_pkg::REG_DIMS, nd);
		if (spare) begin
			write_reg(REG_SPARE_LO, $urandom);
			write_reg(REG_SPARE_HI, $urandom);
		end
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic offer_face(input gsff_pkg::face_t f);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			@(negedge clk);
			s_axis_tvalid = 1'b0;
		end
		@(negedge clk);
		face_drv      = f;
		s_axis_tuser  = f.kind;
		s_axis_tdata  = {f.tb_right_plus, f.tb_right_minus, f.tb_left_plus, f.tb_left_minus,
			f.ta_right_plus, f.ta_right_minus, f.ta_left_plus, f.ta_left_minus,
			f.pot_right, f.pot_left};
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic offer_stencil(input logic [1:0] kind, input logic [31:0] pl, pr,
			a_lm, a_lp, a_rm, a_rp, b_lm, b_lp, b_rm, b_rp);
		gsff_pkg::face_t f;
		f.kind           = kind;
		f.pot_left       = pl;
		f.pot_right      = pr;
		f.ta_left_minus  = a_lm;
		f.ta_left_plus   = a_lp;
		f.ta_right_minus = a_rm;
		f.ta_right_plus  = a_rp;
		f.tb_left_minus  = b_lm;
		f.tb_left_plus   = b_lp;
		f.tb_right_minus = b_rm;
		f.tb_right_plus  = b_rp;
		offer_face(f);
	endtask

	// mostly a smooth potential around one base, some full-range and edge words
	function automatic gsff_pkg::face_t random_face();
		gsff_pkg::face_t f;
		logic [31:0]     base;
		logic [31:0]     word;
		int              spread;
		int              pick;
		int              i;
		pick = $urandom_range(0, 9);
		base = $urandom;
		f.kind = (pick == 9) ? gsff_pkg::KIND_NONE : 2'(pick % 3);
		case ($urandom_range(0, 3))
		0: spread = 0;
		1: spread = 4096;
		2: spread = 1 << 20;
		default: spread = 1 << 26;
		endcase
		for (i = 0; i < 10; i++) begin
			case ($urandom_range(0, 19))
			0: word = POT_MAX;
			1: word = POT_MIN;
			2: word = $urandom;
			default: word = (spread == 0) ? $urandom
				: base + $urandom_range(0, 2 * spread) - spread;
			endcase
			f[32 * (9 - i) +: 32] = word;
		end
		return f;
	endfunction

	// reciprocal register value; bit 31 is not part of the register
	function automatic logic [31:0] rand_recip();
		logic [31:0] v;
		case ($urandom_range(0, 5))
		0: v = 32'd65536;
		1: v = $urandom_range(1, 32'h0010_0000);
		2: v = $urandom;
		3: v = 32'h7FFF_FFFF;
		4: v = 32'd1;
		default: v = $urandom_range(32'h0000_4000, 32'h0004_0000);
		endcase
		v[31] = 1'($urandom_range(0, 1));
		return v;
	endfunction

	function automatic logic [31:0] rand_density();
		case ($urandom_range(0, 4))
		0: return $urandom;
		1: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
		2: return 32'd0;
		3: return POT_MAX;
		default: return POT_MIN;
		endcase
	endfunction

	task automatic drain_results();
		while (sb.flux_due.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int ph;
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = gsff_pkg::REG_INV_FOUR_PI_G;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = gsff_pkg::KIND_AXIS1;
		m_axis_tready = 1'b0;
		face_drv      = '0;
		sb = new();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				drain_results();
				case (ph)
				1: load_registers(32'hFFFF_FFFF, POT_MAX, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
					32'hFFFF_FFFF, 32'd3, 1'b0);
				2: load_registers(32'd1, POT_MIN, 32'd1, 32'h8000_0001, 32'd1, 32'd1, 1'b0);
				// zero reciprocals and zero dimensionality
				3: load_registers(32'd0, 32'hFFFF_FFFF, 32'd0, rand_recip(), 32'h8000_0000,
					32'd0, 1'b1);
				5: load_registers(rand_recip(), rand_density(), rand_recip(), rand_recip(),
					rand_recip(), 32'd2, 1'b0);
				default: load_registers(rand_recip(), rand_density(), rand_recip(),
					rand_recip(), rand_recip(),
					($urandom & 32'hFFFF_FFFC) | $urandom_range(1, 3),
					$urandom_range(0, 3) == 0);
				endcase
			end
			case (ph % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
			default: begin send_idle_pct = 26; recv_stall_pct = 26; end
			endcase
			// block the result side while faces keep coming
			if (ph == 4) begin
				@(posedge clk);
				rx_hold = 300;
			end
			if (ph == 0) begin
				offer_stencil(gsff_pkg::KIND_AXIS1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
				offer_stencil(gsff_pkg::KIND_AXIS1, POT_MAX, POT_MIN,
					0, 0, 0, 0, 0, 0, 0, 0);
				offer_stencil(gsff_pkg::KIND_AXIS1, POT_MIN, POT_MAX,
					0, 0, 0, 0, 0, 0, 0, 0);
				offer_stencil(gsff_pkg::KIND_AXIS2, 0, 0, POT_MAX, POT_MIN, POT_MAX,
					POT_MIN, POT_MIN, POT_MAX, POT_MIN, POT_MAX);
				offer_stencil(gsff_pkg::KIND_AXIS3, POT_MAX, POT_MAX, POT_MAX, POT_MAX,
					POT_MAX, POT_MAX, POT_MAX, POT_MAX, POT_MAX, POT_MAX);
				offer_stencil(gsff_pkg::KIND_AXIS3, POT_MIN, POT_MIN, POT_MIN, POT_MIN,
					POT_MIN, POT_MIN, POT_MIN, POT_MIN, POT_MIN, POT_MIN);
				// no such axis: zero flux whatever the stencil
				offer_stencil(gsff_pkg::KIND_NONE, POT_MAX, POT_MIN, 32'h1234_5678,
					POT_MIN, POT_MAX, 32'h0BAD_F00D, POT_MAX, POT_MIN, 32'hFFFF_FFFF,
					32'd1);
				// quarter weight lands exactly on a half, both signs
				offer_stencil(gsff_pkg::KIND_AXIS1, ONE_Q, 0, 32'd2, 0, 0, 0,
					32'hFFFF_FFFE, 0, 0, 0);
				offer_stencil(gsff_pkg::KIND_AXIS2, 0, ONE_Q, 32'd6, 0, 0, 0, 0, 32'd6,
					0, 0);
				offer_stencil(gsff_pkg::KIND_AXIS3, 32'h0003_0000, 32'hFFFE_0000, ONE_Q,
					32'hFFFF_0000, ONE_Q, 32'hFFFF_0000, 32'd3, 32'd1, 32'hFFFF_FFFD,
					32'd5);
				offer_stencil(gsff_pkg::KIND_AXIS2, 32'hAAAA_AAAA, 32'h5555_5555,
					32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
					32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
				offer_stencil(gsff_pkg::KIND_AXIS1, 32'h5555_5555, 32'hAAAA_AAAA,
					32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
					32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
				offer_stencil(gsff_pkg::KIND_AXIS3, 0, 32'd1, 32'd1, 0, 0, 0, 0, 32'd1,
					0, 0);
			end
			repeat ((ph == 0) ? 77 : 90)
				offer_face(random_face());
			@(negedge clk);
			s_axis_tvalid = 1'b0;
		end

		drain_results();
		repeat (4 * PIPE_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.flux_due.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
